@@ design/sit_pkg.sv @@
//------------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted interval table.
//------------------------------------------------------------------------------
package sit_pkg;
	localparam int DEPTH     = 256;
	localparam int TIME_BITS = 48;
	localparam int KIND_BITS = 8;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int ENT_BITS  = 2 * TIME_BITS + KIND_BITS;

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_LOOKUP = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_MERGE  = 3'd4;
	localparam logic [2:0] REQ_CLEAR  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_RANGE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [TIME_BITS-1:0] start;
		logic [TIME_BITS-1:0] stop;
		logic [KIND_BITS-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic                we;
		logic [IDX_BITS-1:0] waddr;
		entry_t              wdata;
		logic [IDX_BITS-1:0] raddr;
	} mem_req_t;
endpackage

@@ design/sit_ram.sv @@
//------------------------------------------------------------------------------
// sit_ram
// Entry store: one write and one registered read port.
//------------------------------------------------------------------------------
module sit_ram
	import sit_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rdata
);
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

@@ design/sorted_interval_table.sv @@
//------------------------------------------------------------------------------
// sorted_interval_table
// Sorted table of typed intervals held in one entry memory.
//------------------------------------------------------------------------------
// One request at a time: s_tready is high only while idle with no result waiting.
// Entries sit in a memory with a registered read port; insert, remove, lookup and
// merge walk it with one read a cycle. Insert searches for the position and
// then shifts later entries up, remove shifts later entries down, lookup scans
// every entry, read fetches one entry and clear resets the count and bounds.
// Insert, remove and a merge of two or more entries then rebuild the bounds by
// a sweep over the entries held afterwards. The result is held in an output
// register until taken; the next item can be accepted from the cycle after that.
module sorted_interval_table
	import sit_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[2:0], new_start[50:3], new_end[98:51], new_kind[106:99],
	// entry_index[114:107], probe_time[162:115], merge_gap[210:163], zero pad
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], found_index[10:3], hit_start[58:11], hit_end[106:59],
	// hit_kind[114:107], entry_count[123:115], span_start[171:124],
	// span_end[219:172], zero pad
	output logic [223:0] m_tdata
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SRCH  = 9'b000000010,
		S_INS   = 9'b000000100,
		S_REM   = 9'b000001000,
		S_LOOK  = 9'b000010000,
		S_READ  = 9'b000100000,
		S_MERGE = 9'b001000000,
		S_BND   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	entry_t               new_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [TIME_BITS-1:0] probe_q, gap_q;
	logic [CNT_BITS-1:0]  cnt_q, ptr_q, pos_q, last_q;
	logic                 rv_q;      // read data valid for ptr_q-1
	entry_t               cur_q;     // carried entry (insert shift / merge accumulator)
	logic [TIME_BITS-1:0] lo_q, hi_q;
	logic [2:0]           st_q;
	logic [IDX_BITS-1:0]  fi_q;
	entry_t               hit_q;
	logic                 found_q;
	mem_req_t             mreq;
	entry_t               rd;

	sit_ram u_ram (.clk(clk), .req(mreq), .rdata(rd));

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;

	logic [TIME_BITS:0] reach;
	assign reach = {1'b0, cur_q.stop} + {1'b0, gap_q};

	always_comb begin
		mreq = '0;
		mreq.raddr = ptr_q[IDX_BITS-1:0];
		unique case (state_q)
			S_INS: begin
				mreq.we    = rv_q;
				mreq.waddr = IDX_BITS'(ptr_q - 1'b1);
				mreq.wdata = cur_q;
			end
			S_REM: begin
				mreq.we    = rv_q;
				mreq.waddr = IDX_BITS'(ptr_q - 2'd2);
				mreq.wdata = rd;
			end
			S_MERGE: begin
				// write back on a break, and flush the accumulator at the end
				mreq.we    = (rv_q && ptr_q != CNT_BITS'(1) && !(rd.kind == cur_q.kind &&
					{1'b0, rd.start} <= reach)) || (!rv_q && ptr_q == cnt_q + 1'b1);
				mreq.waddr = last_q[IDX_BITS-1:0];
				mreq.wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			m_tvalid <= 1'b0;
			rv_q     <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					new_q.start   <= s_tdata[50:3];
					new_q.stop    <= s_tdata[98:51];
					new_q.kind    <= s_tdata[106:99];
					idx_q         <= s_tdata[114:107];
					probe_q       <= s_tdata[162:115];
					gap_q         <= s_tdata[210:163];
					fi_q          <= '0;
					hit_q         <= '0;
					found_q       <= 1'b0;
					rv_q          <= 1'b0;
					unique case (s_tdata[2:0]) inside
						REQ_INSERT: begin
							ptr_q <= '0;
							if (s_tdata[50:3] >= s_tdata[98:51]) begin
								st_q    <= ST_BAD_RANGE;
								state_q <= S_OUT;
							end else if (cnt_q == CNT_BITS'(DEPTH)) begin
								st_q    <= ST_FULL;
								state_q <= S_OUT;
							end else begin
								st_q    <= ST_OK;
								state_q <= S_SRCH;
							end
						end
						REQ_REMOVE, REQ_READ:
							if ({1'b0, s_tdata[114:107]} >= cnt_q) begin
								st_q    <= ST_BAD_INDEX;
								ptr_q   <= '0;
								state_q <= S_OUT;
							end else begin
								st_q    <= ST_OK;
								ptr_q   <= CNT_BITS'(s_tdata[114:107]) +
									((s_tdata[2:0] == REQ_REMOVE) ? 1'b1 : 1'b0);
								state_q <= (s_tdata[2:0] == REQ_REMOVE) ? S_REM : S_READ;
							end
						REQ_LOOKUP: begin
							st_q    <= ST_OK;
							ptr_q   <= '0;
							state_q <= S_LOOK;
						end
						REQ_MERGE: begin
							st_q    <= ST_OK;
							ptr_q   <= '0;
							last_q  <= '0;
							state_q <= (cnt_q >= 2) ? S_MERGE : S_OUT;
						end
						REQ_CLEAR: begin
							st_q    <= ST_OK;
							ptr_q   <= '0;
							cnt_q   <= '0; lo_q <= '0; hi_q <= '0;
							state_q <= S_OUT;
						end
						default: begin
							st_q    <= ST_OK;
							ptr_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_SRCH: begin
					// rd is entry ptr_q-1 when rv_q
					if (rv_q && rd.start >= new_q.start) begin
						pos_q   <= ptr_q - 1'b1;
						ptr_q   <= ptr_q - 1'b1;
						cur_q   <= new_q;
						rv_q    <= 1'b0;
						state_q <= S_INS;
					end else if ((rv_q && ptr_q == cnt_q) || cnt_q == 0) begin
						pos_q   <= cnt_q;
						ptr_q   <= cnt_q;
						cur_q   <= new_q;
						rv_q    <= 1'b0;
						state_q <= S_INS;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rv_q  <= ptr_q < cnt_q;
					end
				end
				S_INS: begin
					// write cur at ptr-1 then carry the old entry onward
					if (rv_q) begin
						cur_q <= rd;
						if (ptr_q - 1'b1 == cnt_q) begin
							cnt_q   <= cnt_q + 1'b1;
							fi_q    <= pos_q[IDX_BITS-1:0];
							ptr_q   <= '0;
							rv_q    <= 1'b0;
							state_q <= S_BND;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rv_q  <= 1'b1;
					end
				end
				S_REM: begin
					if (rv_q && ptr_q - 1'b1 == cnt_q - 1'b1 || ptr_q == cnt_q && !rv_q) begin
						cnt_q   <= cnt_q - 1'b1;
						ptr_q   <= '0;
						rv_q    <= 1'b0;
						state_q <= S_BND;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rv_q  <= 1'b1;
					end
				end
				S_READ: begin
					if (rv_q) begin
						hit_q   <= rd;
						fi_q    <= idx_q;
						state_q <= S_OUT;
					end
					rv_q <= 1'b1;
				end
				S_LOOK: begin
					if (rv_q && rd.start <= probe_q && rd.stop > probe_q) begin
						hit_q   <= rd;
						fi_q    <= IDX_BITS'(ptr_q - 1'b1);
						found_q <= 1'b1;
					end
					if ((rv_q && ptr_q == cnt_q) || cnt_q == 0) begin
						if (!(found_q || (rv_q && rd.start <= probe_q && rd.stop > probe_q)))
							st_q <= ST_NOT_FOUND;
						state_q <= S_OUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rv_q  <= ptr_q < cnt_q;
					end
				end
				S_MERGE: begin
					if (rv_q) begin
						if (ptr_q == 1) cur_q <= rd;
						else if (rd.kind == cur_q.kind && {1'b0, rd.start} <= reach) begin
							if (rd.stop > cur_q.stop) cur_q.stop <= rd.stop;
						end else begin
							last_q <= last_q + 1'b1;
							cur_q  <= rd;
						end
					end
					if (rv_q && ptr_q == cnt_q) begin
						ptr_q   <= ptr_q + 1'b1;
						rv_q    <= 1'b0;
					end else if (!rv_q && ptr_q == cnt_q + 1'b1) begin
						// flush accumulator
						ptr_q   <= '0;
						cnt_q   <= last_q + 1'b1;
						state_q <= S_BND;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rv_q  <= 1'b1;
					end
				end
				S_BND: begin
					if (cnt_q == 0) begin
						lo_q <= '0; hi_q <= '0;
						state_q <= S_OUT;
					end else begin
						if (rv_q) begin
							if (ptr_q == 1) begin
								lo_q <= rd.start;
								hi_q <= rd.stop;
							end else if (rd.stop > hi_q) hi_q <= rd.stop;
						end
						if (rv_q && ptr_q == cnt_q) begin
							state_q <= S_OUT;
						end else begin
							ptr_q <= ptr_q + 1'b1;
							rv_q  <= 1'b1;
						end
					end
				end
				S_OUT: if (!m_tvalid) begin
					m_tvalid <= 1'b1;
					m_tdata  <= {4'd0, hi_q, lo_q, cnt_q, hit_q.kind, hit_q.stop,
						hit_q.start, fi_q, st_q};
					rv_q     <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(DEPTH)) else $error("count over depth");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE) else $error("ready while busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("two items taken");
`endif
endmodule

@@ dv/sit_table_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// sit_table_checker
// Watches both item channels of the sorted interval table, keeps its own copy
// of the table, works out the answer to every accepted request and compares
// each answer taken from the block, field by field, with the oldest one due.
//------------------------------------------------------------------------------
package sit_tb_pkg;
	typedef struct packed {
		logic [4:0]  pad;
		logic [47:0] merge_gap;
		logic [47:0] probe_time;
		logic [7:0]  entry_index;
		logic [7:0]  new_kind;
		logic [47:0] new_end;
		logic [47:0] new_start;
		logic [2:0]  req_type;
	} table_req_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic [47:0] span_end;
		logic [47:0] span_start;
		logic [8:0]  entry_count;
		logic [7:0]  hit_kind;
		logic [47:0] hit_end;
		logic [47:0] hit_start;
		logic [7:0]  found_index;
		logic [2:0]  status;
	} table_resp_t;
endpackage

module sit_table_checker
	import sit_pkg::*;
	import sit_tb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [215:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [223:0] m_tdata,
	output int           failures,
	output int           pending
);
	logic [TIME_BITS-1:0] iv_start [DEPTH];
	logic [TIME_BITS-1:0] iv_end [DEPTH];
	logic [KIND_BITS-1:0] iv_kind [DEPTH];
	logic [CNT_BITS-1:0]  iv_count;
	logic [TIME_BITS-1:0] span_lo;
	logic [TIME_BITS-1:0] span_hi;
	table_resp_t          answers_due[$];

	function automatic void rebuild_span();
		span_lo = 0;
		span_hi = 0;
		if (iv_count != 0) begin
			span_lo = iv_start[0];
			for (int i = 0; i < iv_count; i++)
				if (iv_end[i] > span_hi)
					span_hi = iv_end[i];
		end
	endfunction

	function automatic table_resp_t apply_request(table_req_t r);
		table_resp_t a;
		int          p;
		int          last;
		logic        near;
		a = '0;
		case (r.req_type)
			REQ_INSERT: begin
				if (r.new_start >= r.new_end)
					a.status = ST_BAD_RANGE;
				else if (iv_count >= DEPTH)
					a.status = ST_FULL;
				else begin
					p = 0;
					while (p < iv_count && iv_start[p] < r.new_start)
						p++;
					for (int i = iv_count; i > p; i--) begin
						iv_start[i] = iv_start[i-1];
						iv_end[i]   = iv_end[i-1];
						iv_kind[i]  = iv_kind[i-1];
					end
					iv_start[p] = r.new_start;
					iv_end[p]   = r.new_end;
					iv_kind[p]  = r.new_kind;
					iv_count++;
					a.found_index = p[7:0];
					rebuild_span();
				end
			end
			REQ_REMOVE: begin
				if (r.entry_index >= iv_count)
					a.status = ST_BAD_INDEX;
				else begin
					for (int i = r.entry_index; i + 1 < iv_count; i++) begin
						iv_start[i] = iv_start[i+1];
						iv_end[i]   = iv_end[i+1];
						iv_kind[i]  = iv_kind[i+1];
					end
					iv_count--;
					rebuild_span();
				end
			end
			REQ_LOOKUP: begin
				a.status = ST_NOT_FOUND;
				for (int i = iv_count - 1; i >= 0; i--)
					if (a.status == ST_NOT_FOUND && iv_start[i] <= r.probe_time
							&& iv_end[i] > r.probe_time) begin
						a.status      = ST_OK;
						a.found_index = i[7:0];
						a.hit_start   = iv_start[i];
						a.hit_end     = iv_end[i];
						a.hit_kind    = iv_kind[i];
					end
			end
			REQ_READ: begin
				if (r.entry_index >= iv_count)
					a.status = ST_BAD_INDEX;
				else begin
					a.found_index = r.entry_index;
					a.hit_start   = iv_start[r.entry_index];
					a.hit_end     = iv_end[r.entry_index];
					a.hit_kind    = iv_kind[r.entry_index];
				end
			end
			REQ_MERGE: begin
				if (iv_count >= 2) begin
					last = 0;
					for (int i = 1; i < iv_count; i++) begin
						near = (iv_start[i] <= iv_end[last])
							|| (iv_start[i] - iv_end[last] <= r.merge_gap);
						if (iv_kind[last] == iv_kind[i] && near) begin
							if (iv_end[i] > iv_end[last])
								iv_end[last] = iv_end[i];
						end else begin
							last++;
							iv_start[last] = iv_start[i];
							iv_end[last]   = iv_end[i];
							iv_kind[last]  = iv_kind[i];
						end
					end
					iv_count = CNT_BITS'(last + 1);
					rebuild_span();
				end
			end
			REQ_CLEAR: begin
				iv_count = 0;
				rebuild_span();
			end
			default: ;
		endcase
		a.entry_count = iv_count;
		a.span_start  = span_lo;
		a.span_end    = span_hi;
		return a;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_resp_t want;
		table_resp_t got;
		if (!arst_n) begin
			iv_count = 0;
			span_lo  = 0;
			span_hi  = 0;
			failures = 0;
			pending  = 0;
			answers_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (answers_due.size() == 0) begin
					$error("result item with none due: %h", m_tdata);
					failures++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("found_index", 64'(want.found_index),
						64'(got.found_index));
					check_field("hit_start", 64'(want.hit_start), 64'(got.hit_start));
					check_field("hit_end", 64'(want.hit_end), 64'(got.hit_end));
					check_field("hit_kind", 64'(want.hit_kind), 64'(got.hit_kind));
					check_field("entry_count", 64'(want.entry_count),
						64'(got.entry_count));
					check_field("span_start", 64'(want.span_start), 64'(got.span_start));
					check_field("span_end", 64'(want.span_end), 64'(got.span_end));
				end
			end
			if (s_tvalid && s_tready)
				answers_due.push_back(apply_request(s_tdata));
			pending = answers_due.size();
		end
	end
endmodule

@@ dv/tb_sorted_interval_table.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_sorted_interval_table
// Stimulus and verdict for the sorted interval table.
// A directed opening covers the edge cases, then random request mixes, a
// fill to a full table and a final stretch run at full rate; both sides idle
// in random bursts, and the checker beside the block judges every answer.
//------------------------------------------------------------------------------
module tb_sorted_interval_table;
	import sit_pkg::*;
	import sit_tb_pkg::*;

	localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [223:0] m_tdata;
	int           failures;
	int           pending;
	int           sent_items;
	bit           quiet;
	bit           held_once;

	sorted_interval_table uut (.*);

	sit_table_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("sorted_interval_table verification failed");
		$finish;
	end

	function automatic logic [47:0] any_time();
		if ($urandom_range(0, 3) == 0)
			return 48'({$urandom, $urandom});
		return 48'($urandom_range(0, 2000));
	endfunction

	function automatic table_req_t make_req(logic [2:0] op);
		table_req_t r;
		r.pad         = '0;
		r.req_type    = op;
		r.new_start   = any_time();
		r.new_end     = any_time();
		if ($urandom_range(0, 6) != 0)
			r.new_end = r.new_start + 48'($urandom_range(1, 300));
		if (r.new_end == 0)
			r.new_end = TMAX;
		r.new_kind    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 3));
		r.entry_index = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 20));
		r.probe_time  = any_time();
		r.merge_gap   = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom})
			: 48'($urandom_range(0, 50));
		return r;
	endfunction

	function automatic table_req_t rand_req();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return make_req(REQ_INSERT);
		if (k < 50) return make_req(REQ_REMOVE);
		if (k < 65) return make_req(REQ_LOOKUP);
		if (k < 78) return make_req(REQ_READ);
		if (k < 88) return make_req(REQ_MERGE);
		if (k < 92) return make_req(REQ_CLEAR);
		return make_req(3'($urandom_range(6, 7)));
	endfunction

	function automatic table_req_t fixed_req(logic [2:0] op, logic [47:0] a,
			logic [47:0] b, logic [7:0] kind, logic [7:0] idx);
		table_req_t r;
		r             = '0;
		r.req_type    = op;
		r.new_start   = a;
		r.new_end     = b;
		r.probe_time  = a;
		r.merge_gap   = a;
		r.new_kind    = kind;
		r.entry_index = idx;
		return r;
	endfunction

	task automatic send(table_req_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
	endtask

	// result side: short random stalls, one long hold-off to back the block up
	initial begin
		m_tready  = 1'b0;
		held_once = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_once && sent_items >= 300) begin
				held_once = 1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		arst_n     = 1'b0;
		sent_items = 0;
		quiet      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(fixed_req(REQ_CLEAR, 0, 0, 0, 0));
		send(fixed_req(REQ_MERGE, 0, 0, 0, 0));
		send(fixed_req(REQ_READ, 0, 0, 0, 0));
		send(fixed_req(REQ_REMOVE, 0, 0, 0, 0));
		send(fixed_req(REQ_LOOKUP, 0, 0, 0, 0));
		send(fixed_req(REQ_INSERT, 5, 5, 1, 0));
		send(fixed_req(REQ_INSERT, TMAX, 0, 1, 0));
		send(fixed_req(REQ_INSERT, 100, 200, 1, 0));
		send(fixed_req(REQ_INSERT, 0, TMAX, 8'hFF, 0));
		send(fixed_req(REQ_INSERT, 100, 150, 1, 0));
		send(fixed_req(REQ_INSERT, TMAX - 1, TMAX, 8'h80, 0));
		send(fixed_req(REQ_LOOKUP, 120, 0, 0, 0));
		send(fixed_req(REQ_LOOKUP, 300, 0, 0, 0));
		send(fixed_req(REQ_LOOKUP, TMAX, 0, 0, 0));
		send(fixed_req(REQ_LOOKUP, TMAX - 1, 0, 0, 0));
		send(fixed_req(REQ_READ, 0, 0, 0, 3));
		send(fixed_req(REQ_READ, 0, 0, 0, 4));
		send(fixed_req(3'd6, TMAX, TMAX, 8'hFF, 8'hFF));
		send(fixed_req(3'd7, 0, 0, 0, 0));
		send(fixed_req(REQ_MERGE, 0, 0, 0, 0));
		send(fixed_req(REQ_INSERT, 400, 500, 1, 0));
		send(fixed_req(REQ_MERGE, TMAX, 0, 0, 0));
		send(fixed_req(REQ_REMOVE, 0, 0, 0, 0));
		send(fixed_req(REQ_REMOVE, 0, 0, 0, 8'hFF));
		send(fixed_req(REQ_CLEAR, 0, 0, 0, 0));

		repeat (800) send(rand_req());

		// sender pause until the table has answered everything
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		send(fixed_req(REQ_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < 260; i++) begin
			send(fixed_req(REQ_INSERT, 48'((i * 37) % 5000), 48'((i * 37) % 5000 + 20),
				8'(i % 3), 0));
			if (i % 16 == 0)
				send(make_req(REQ_LOOKUP));
		end
		send(fixed_req(REQ_INSERT, 1, 2, 0, 0));
		send(fixed_req(REQ_READ, 0, 0, 0, 8'hFF));
		send(fixed_req(REQ_REMOVE, 0, 0, 0, 8'hFF));
		send(fixed_req(REQ_MERGE, TMAX, 0, 0, 0));
		send(fixed_req(REQ_CLEAR, 0, 0, 0, 0));

		repeat (600) send(rand_req());
		quiet = 1;
		repeat (200) send(rand_req());
		s_tvalid <= 1'b0;

		for (int n = 0; n < 2_000_000 && pending != 0; n++)
			@(posedge clk);
		repeat (800) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("sorted_interval_table verification clean");
		else
			$display("sorted_interval_table verification failed");
		$finish;
	end
endmodule

@@ files.f @@
design/sit_pkg.sv
design/sit_ram.sv
design/sorted_interval_table.sv
dv/sit_table_checker.sv
dv/tb_sorted_interval_table.sv
